// File: src/catmull_rom_table_fill_assert.svh
// Assertion macros for the Catmull-Rom table fill block.
// Used by the top level only; needs no other file.
`ifndef CATMULL_ROM_TABLE_FILL_ASSERT_SVH
`define CATMULL_ROM_TABLE_FILL_ASSERT_SVH

// Implication checked in the same cycle.
`define CRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("catmull_rom_table_fill: assertion failed");

// Implication checked in the next cycle.
`define CRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("catmull_rom_table_fill: assertion failed");

`endif

// File: src/crt_fill_pkg.sv
// Package for the Catmull-Rom table fill block: payload types, states, constants.
// Depends on nothing.
package crt_fill_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MAX_TABLE_DEF  = 64;
    localparam logic [6:0] TABLE_SIZE_RST = 7'd64;

    // Configuration register indexes.
    localparam logic CFG_TABLE_SIZE  = 1'b0;
    localparam logic CFG_NEGATE_MODE = 1'b1;

    typedef struct packed {
        logic               point_present;
        logic [7:0]         point_index;
        logic signed [23:0] point_value;
        logic               last_point;
    } request_t;

    typedef struct packed {
        logic [5:0]         entry_position;
        logic signed [15:0] entry_value;
        logic               last_entry;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCAN, ST_INS, ST_FIX0, ST_SEEK,
        ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_DIV, ST_COEF,
        ST_MUL1, ST_ADD1, ST_MUL2, ST_ADD2, ST_MUL3, ST_ADD3, ST_RND
    } state_t;

endpackage

// File: src/catmull_rom_table_fill.sv
// Top level of the Catmull-Rom table fill block: point store, sequencer, shared datapath.
// Depends on crt_fill_pkg and catmull_rom_table_fill_assert.svh.
//
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          request (request_t)
// result    out        done, one-cycle strobe result (result_t)
// config    in         cfg_write              cfg_index, cfg_data
//
// Loading a point passes through a scan that steps past each held point below it,
// then an insert step when it is inserted as a new point.
// Each interpolated entry takes four store reads, a 16-step restoring divider
// for t, and three passes through one shared multiplier.
// Entries at or outside a point skip these and go from the seek straight to rounding.
// Reset is asynchronous and clears the control state; the store needs no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
`include "catmull_rom_table_fill_assert.svh"

module catmull_rom_table_fill
    import crt_fill_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_TABLE  = MAX_TABLE_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    input  logic     cfg_write,
    input  logic     cfg_index,
    input  logic [6:0] cfg_data,
    output logic     done,
    output result_t  result
);

    localparam int DEPTH = MAX_POINTS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [6:0] TABLE_MAX = 7'(MAX_TABLE);

    // Point store.
    logic [7:0]         pos_mem [DEPTH];
    logic signed [23:0] val_mem [DEPTH];

    state_t state_reg, state_next;

    logic [6:0]       table_size_reg;
    logic             negate_reg;
    request_t         req_reg, req_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [6:0]       i_reg, i_next;
    logic [6:0]       size_reg, size_next;
    logic [7:0]       a_reg, a_next;
    logic [7:0]       d_reg, d_next;
    logic [8:0]       rem_reg, rem_next;
    logic [15:0]      t_reg, t_next;
    logic [3:0]       step_reg, step_next;
    logic signed [23:0] p0_reg, p0_next, p1_reg, p1_next;
    logic signed [23:0] p2_reg, p2_next, p3_reg, p3_next;
    logic signed [27:0] c1_reg, c1_next, c2_reg, c2_next, c3_reg, c3_next;
    logic signed [47:0] s_reg, s_next;
    logic signed [64:0] prod_reg, prod_next;
    logic signed [65:0] n_reg, n_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    // Store control.
    logic             mem_wr_val;
    logic             mem_ins;
    logic [CNT_W-1:0] rd_addr;
    logic [7:0]       rd_pos;
    logic signed [23:0] rd_val;

    // Shared arithmetic.
    logic signed [47:0] mul_a;
    logic signed [64:0] mul_p;
    logic [8:0]         rem_sh;
    logic [65:0]        mag;
    logic [24:0]        q;
    logic               neg_out;
    logic [6:0]         size_clamp;

    assign rd_pos = pos_mem[rd_addr[IDX_W-1:0]];
    assign rd_val = val_mem[rd_addr[IDX_W-1:0]];
    assign mul_p  = mul_a * $signed({1'b0, t_reg});
    assign rem_sh = {rem_reg[7:0], 1'b0};
    assign mag    = n_reg[65] ? 66'(-n_reg) : 66'(n_reg);
    assign q      = 25'((mag + (66'd1 << 40)) >> 41);
    assign neg_out = n_reg[65] ^ negate_reg;
    assign size_clamp = (table_size_reg > TABLE_MAX) ? TABLE_MAX : table_size_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            negate_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE:  table_size_reg <= cfg_data;
                CFG_NEGATE_MODE: negate_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Point store: value overwrite or shifting insertion at j.
    always_ff @(posedge clk)
    begin
        if (mem_wr_val)
            val_mem[j_reg[IDX_W-1:0]] <= req_reg.point_value;
        if (mem_ins)
        begin
            for (int c = 1; c < DEPTH; c++)
            begin
                if (CNT_W'(c) > j_reg && CNT_W'(c) <= cnt_reg)
                begin
                    pos_mem[c] <= pos_mem[c-1];
                    val_mem[c] <= val_mem[c-1];
                end
            end
            pos_mem[j_reg[IDX_W-1:0]] <= req_reg.point_index;
            val_mem[j_reg[IDX_W-1:0]] <= req_reg.point_value;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = request.point_present ? ST_SCAN :
                                 (request.last_point ? ST_FIX0 : ST_IDLE);
            ST_SCAN:
                if (!(j_reg < cnt_reg && rd_pos < req_reg.point_index))
                begin
                    if (j_reg < cnt_reg && rd_pos == req_reg.point_index)
                        state_next = req_reg.last_point ? ST_FIX0 : ST_IDLE;
                    else if (cnt_reg < CNT_MAX)
                        state_next = ST_INS;
                    else
                        state_next = req_reg.last_point ? ST_FIX0 : ST_IDLE;
                end
            ST_INS:
                state_next = req_reg.last_point ? ST_FIX0 : ST_IDLE;
            ST_FIX0:
                if (cnt_reg == '0 || rd_pos != 8'd0)
                    state_next = ST_INS;
                else
                    state_next = (size_clamp == 7'd0) ? ST_IDLE : ST_SEEK;
            ST_SEEK:
                if (!(k_reg < cnt_reg && {1'b0, rd_pos} < {2'b00, i_reg}))
                begin
                    if (k_reg == '0 || k_reg >= cnt_reg || {1'b0, rd_pos} == {2'b00, i_reg})
                        state_next = ST_RND;
                    else
                        state_next = ST_RD0;
                end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == 4'd15) state_next = ST_COEF;
            ST_COEF: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_ADD1;
            ST_ADD1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_ADD2;
            ST_ADD2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_ADD3;
            ST_ADD3: state_next = ST_RND;
            ST_RND:  state_next = (i_reg + 7'd1 == size_reg) ? ST_IDLE : ST_SEEK;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and store control.
    always_comb
    begin
        req_next = req_reg;   cnt_next = cnt_reg;   j_next = j_reg;
        k_next = k_reg;       i_next = i_reg;       size_next = size_reg;
        a_next = a_reg;       d_next = d_reg;       rem_next = rem_reg;
        t_next = t_reg;       step_next = step_reg;
        p0_next = p0_reg;     p1_next = p1_reg;     p2_next = p2_reg;
        p3_next = p3_reg;     c1_next = c1_reg;     c2_next = c2_reg;
        c3_next = c3_reg;     s_next = s_reg;       prod_next = prod_reg;
        n_next = n_reg;       done_next = 1'b0;     result_next = result_reg;
        mem_wr_val = 1'b0;    mem_ins = 1'b0;       rd_addr = j_reg;
        mul_a = 48'(c3_reg);
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    req_next = request;
                    j_next   = '0;
                end
            ST_SCAN:
                if (j_reg < cnt_reg && rd_pos < req_reg.point_index)
                    j_next = j_reg + 1'b1;
                else if (j_reg < cnt_reg && rd_pos == req_reg.point_index)
                    mem_wr_val = 1'b1;
            ST_INS:
            begin
                mem_ins  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_FIX0:
            begin
                rd_addr = '0;
                if (cnt_reg == '0 || rd_pos != 8'd0)
                begin
                    // Add the point (0, 0) in front.
                    j_next = '0;
                    req_next.point_index = 8'd0;
                    req_next.point_value = 24'sd0;
                end
                else
                begin
                    size_next = size_clamp;
                    i_next    = 7'd0;
                    k_next    = '0;
                    if (size_clamp == 7'd0)
                        cnt_next = '0;
                end
            end
            ST_SEEK:
            begin
                rd_addr = k_reg;
                if (k_reg < cnt_reg && {1'b0, rd_pos} < {2'b00, i_reg})
                    k_next = k_reg + 1'b1;
                else if (k_reg == '0 || k_reg >= cnt_reg ||
                         {1'b0, rd_pos} == {2'b00, i_reg})
                begin
                    // Constant entry: first, last or exact point.
                    if (k_reg >= cnt_reg)
                        rd_addr = cnt_reg - 1'b1;
                    n_next = 66'(rd_val) <<< 33;
                end
            end
            ST_RD0:
            begin
                rd_addr = (k_reg >= CNT_W'(2)) ? k_reg - CNT_W'(2) : '0;
                p0_next = rd_val;
            end
            ST_RD1:
            begin
                rd_addr  = k_reg - 1'b1;
                p1_next  = rd_val;
                a_next   = rd_pos;
                rem_next = 9'(i_reg) - 9'(rd_pos);
            end
            ST_RD2:
            begin
                rd_addr = k_reg;
                p2_next = rd_val;
                d_next  = rd_pos - a_reg;
            end
            ST_RD3:
            begin
                rd_addr   = (k_reg + 1'b1 < cnt_reg) ? k_reg + 1'b1 : cnt_reg - 1'b1;
                p3_next   = rd_val;
                step_next = 4'd0;
            end
            ST_DIV:
            begin
                // One quotient bit of (i - a) * 2^16 / (b - a) per cycle.
                if (rem_sh >= {1'b0, d_reg})
                begin
                    rem_next = rem_sh - {1'b0, d_reg};
                    t_next   = {t_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    t_next   = {t_reg[14:0], 1'b0};
                end
                step_next = step_reg + 4'd1;
            end
            ST_COEF:
            begin
                c1_next = 28'(p2_reg) - 28'(p0_reg);
                c2_next = (28'(p0_reg) <<< 1) - 28'(p1_reg) * 28'sd5
                          + (28'(p2_reg) <<< 2) - 28'(p3_reg);
                c3_next = (28'(p1_reg) - 28'(p2_reg)) * 28'sd3 + 28'(p3_reg) - 28'(p0_reg);
            end
            ST_MUL1:
            begin
                mul_a     = 48'(c3_reg);
                prod_next = mul_p;
            end
            ST_ADD1:
                s_next = (48'(c2_reg) <<< 16) + 48'(prod_reg);
            ST_MUL2:
            begin
                mul_a     = s_reg;
                prod_next = mul_p;
            end
            ST_ADD2:
                s_next = (48'(c1_reg) <<< 16) + 48'(prod_reg >>> 16);
            ST_MUL3:
            begin
                mul_a     = s_reg;
                prod_next = mul_p;
            end
            ST_ADD3:
                n_next = (66'(p1_reg) <<< 33) + 66'(prod_reg);
            ST_RND:
            begin
                // Round half away from zero, apply negation, saturate.
                done_next = 1'b1;
                result_next.entry_position = i_reg[5:0];
                result_next.last_entry     = (i_reg + 7'd1 == size_reg);
                if (neg_out)
                    result_next.entry_value = (q > 25'd32768) ? 16'sh8000 :
                                              16'(-$signed({1'b0, q}));
                else
                    result_next.entry_value = (q > 25'd32767) ? 16'sd32767 : 16'(q);
                i_next = i_reg + 7'd1;
                if (i_reg + 7'd1 == size_reg)
                    cnt_next = '0;
            end
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;   j_reg    <= j_next;    k_reg    <= k_next;
        i_reg    <= i_next;     size_reg <= size_next; a_reg    <= a_next;
        d_reg    <= d_next;     rem_reg  <= rem_next;  t_reg    <= t_next;
        step_reg <= step_next;  p0_reg   <= p0_next;   p1_reg   <= p1_next;
        p2_reg   <= p2_next;    p3_reg   <= p3_next;   c1_reg   <= c1_next;
        c2_reg   <= c2_next;    c3_reg   <= c3_next;   s_reg    <= s_next;
        prod_reg <= prod_next;  n_reg    <= n_next;    result_reg <= result_next;
    end

    // Checks.
    `CRT_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `CRT_ASSERT_NEXT(a_req_busy, clk, rst_n, start && !busy && (request.point_present || request.last_point), busy)
    `CRT_ASSERT_NOW(a_done_only_mid_table, clk, rst_n, done && !result.last_entry, busy)

endmodule

// File: tb/testbench.sv
// Testbench for the Catmull-Rom table fill block: random and directed point sets,
// predicted table entries checked against the result strobe. Depends on crt_fill_pkg.
module testbench;
    import crt_fill_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       start = 1'b0;
    logic       busy;
    request_t   request = '0;
    logic       cfg_write;
    logic       cfg_index;
    logic [6:0] cfg_data;
    logic       done;
    result_t    result;

    catmull_rom_table_fill dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    // Requests waiting for the driver, and table entries waiting for the monitor.
    request_t pending_requests[$];
    result_t  expected_entries[$];
    int       error_count = 0;
    int       accepted_count = 0;
    logic     driver_idle = 1'b1;

    // Predictor state.
    logic [7:0]  knot_pos[0:16];
    longint      knot_val[0:16];
    int          knot_count = 0;
    logic [6:0]  model_table_size = TABLE_SIZE_RST;
    logic        model_negate = 1'b0;

    always #6 clk = ~clk;

    function automatic longint round_q41(longint n);
        longint m;
        longint q;
        m = (n >= 0) ? n : -n;
        q = (m + (64'sd1 <<< 40)) >>> 41;
        return (n >= 0) ? q : -q;
    endfunction

    function automatic longint floor_q16(longint x);
        return x >>> 16;
    endfunction

    function automatic void place_knot(int at, logic [7:0] pos, longint val);
        for (int k = knot_count; k > at; k--)
        begin
            knot_pos[k] = knot_pos[k - 1];
            knot_val[k] = knot_val[k - 1];
        end
        knot_pos[at] = pos;
        knot_val[at] = val;
        knot_count++;
    endfunction

    // Catmull-Rom value at one table position, before negation and saturation.
    function automatic longint spline_at(int i);
        int k;
        int a;
        int b;
        int i0;
        int i3;
        longint p0, p1, p2, p3, c1, c2, c3, s1, s2, t;
        k = 0;
        while (k < knot_count && knot_pos[k] < i)
            k++;
        if (k == 0)
            return round_q41(knot_val[0] <<< 33);
        if (k >= knot_count)
            return round_q41(knot_val[knot_count - 1] <<< 33);
        if (knot_pos[k] == i)
            return round_q41(knot_val[k] <<< 33);
        a = knot_pos[k - 1];
        b = knot_pos[k];
        t = ((longint'(i - a)) <<< 16) / (b - a);
        i0 = (k >= 2) ? k - 2 : 0;
        i3 = (k + 1 < knot_count) ? k + 1 : knot_count - 1;
        p0 = knot_val[i0];
        p1 = knot_val[k - 1];
        p2 = knot_val[k];
        p3 = knot_val[i3];
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = 3 * (p1 - p2) + p3 - p0;
        s2 = c2 * 65536 + c3 * t;
        s1 = c1 * 65536 + floor_q16(s2 * t);
        return round_q41((p1 <<< 33) + s1 * t);
    endfunction

    // Applies one accepted request to the point store and queues any table entries.
    function automatic void predict_request(request_t req);
        int j;
        int size;
        longint r;
        result_t entry;
        if (req.point_present)
        begin
            j = 0;
            while (j < knot_count && knot_pos[j] < req.point_index)
                j++;
            if (j < knot_count && knot_pos[j] == req.point_index)
                knot_val[j] = req.point_value;
            else if (knot_count < 16)
                place_knot(j, req.point_index, req.point_value);
        end
        if (!req.last_point)
            return;
        if (knot_count == 0 || knot_pos[0] != 0)
            place_knot(0, 8'd0, 0);
        size = (model_table_size > 64) ? 64 : model_table_size;
        for (int i = 0; i < size; i++)
        begin
            r = spline_at(i);
            if (model_negate)
                r = -r;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            entry.entry_position = i[5:0];
            entry.entry_value = r[15:0];
            entry.last_entry = (i + 1 == size);
            expected_entries = {expected_entries, entry};
        end
        knot_count = 0;
    endfunction

    function automatic request_t make_point(logic [7:0] pos, logic [23:0] val, logic last);
        request_t req;
        req.point_present = 1'b1;
        req.point_index = pos;
        req.point_value = val;
        req.last_point = last;
        return req;
    endfunction

    // Appends one request to the driver's queue.
    function automatic void queue_request(request_t req);
        pending_requests = {pending_requests, req};
    endfunction

    // Random set: one value style per set: small, full-scale or (most often) mid-range.
    task automatic queue_random_set();
        int n;
        int style;
        request_t req;
        n = $urandom_range(0, 20);
        style = $urandom_range(0, 3);
        for (int k = 0; k <= n; k++)
        begin
            req.point_present = ($urandom_range(0, 9) != 0);
            req.point_index = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 70));
            case (style)
                0: req.point_value = 24'($signed($urandom_range(0, 20000)) - 10000);
                1: req.point_value = 24'($urandom);
                default: req.point_value = 24'($signed($urandom_range(0, 4000000)) - 2000000);
            endcase
            req.last_point = (k == n);
            queue_request(req);
        end
    endtask

    task automatic write_register(logic idx, logic [6:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_TABLE_SIZE)
            model_table_size = data;
        else
            model_negate = data[0];
    endtask

    // Waits for the driver to drain and every entry to arrive, then for the tail.
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || !driver_idle || expected_entries.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Driver: bursts of requests with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_request(request);
                accepted_count++;
            end
            if (start && busy)
            begin
                // Hold the request until the block takes it.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
                driver_idle <= 1'b1;
            end
            else if (pending_requests.size() != 0)
            begin
                request <= pending_requests.pop_front();
                start <= 1'b1;
                driver_idle <= 1'b0;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                start <= 1'b0;
                driver_idle <= 1'b1;
            end
        end
    end

    // Monitor: every strobed entry is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_entries.size() == 0)
            begin
                $display("%0t: unexpected entry %p", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_entries.pop_front();
                if (result.entry_position !== want.entry_position)
                begin
                    $display("%0t: entry_position expected %0d actual %0d", $time,
                             want.entry_position, result.entry_position);
                    error_count++;
                end
                if (result.entry_value !== want.entry_value)
                begin
                    $display("%0t: entry_value expected %0d actual %0d", $time,
                             want.entry_value, result.entry_value);
                    error_count++;
                end
                if (result.last_entry !== want.last_entry)
                begin
                    $display("%0t: last_entry expected %0b actual %0b", $time,
                             want.last_entry, result.last_entry);
                    error_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_TABLE_SIZE;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, extremes, exact hits, repeats and a full store.
        queue_request('{1'b0, 8'd0, 24'sd0, 1'b1});
        queue_request(make_point(8'd0, 24'h7FFFFF, 1'b0));
        queue_request(make_point(8'd255, 24'h800000, 1'b0));
        queue_request(make_point(8'd10, 24'h800000, 1'b0));
        queue_request(make_point(8'd20, 24'h7FFFFF, 1'b1));
        queue_request(make_point(8'd5, 24'd2560, 1'b0));
        queue_request(make_point(8'd5, 24'hFFF600, 1'b0));
        queue_request(make_point(8'd40, 24'd1280, 1'b0));
        queue_request(make_point(8'd63, 24'd128, 1'b1));
        for (int k = 0; k < 18; k++)
            queue_request(make_point(8'(k * 3 + 1), 24'(k * 777 - 5000), k == 17));
        wait_quiet();

        write_register(CFG_NEGATE_MODE, 7'd1);
        write_register(CFG_TABLE_SIZE, 7'd127);
        queue_request(make_point(8'd0, 24'h800000, 1'b0));
        queue_request(make_point(8'd30, 24'h7FFFFF, 1'b1));
        wait_quiet();
        write_register(CFG_TABLE_SIZE, 7'd0);
        queue_request(make_point(8'd3, 24'd99, 1'b1));
        wait_quiet();
        write_register(CFG_TABLE_SIZE, 7'd1);
        write_register(CFG_NEGATE_MODE, 7'd0);
        queue_request(make_point(8'd0, 24'd383, 1'b1));
        queue_request(make_point(8'd0, 24'hFFFE80, 1'b1));
        wait_quiet();

        // Random phases with changing settings.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_register(CFG_TABLE_SIZE, 7'd64);
                1: write_register(CFG_TABLE_SIZE, 7'($urandom_range(1, 63)));
                2: write_register(CFG_NEGATE_MODE, 7'd1);
                3: write_register(CFG_TABLE_SIZE, 7'($urandom_range(65, 127)));
                4: write_register(CFG_NEGATE_MODE, 7'd0);
                default: write_register(CFG_TABLE_SIZE, 7'd2);
            endcase
            while (accepted_count < 55 * (phase + 1) + 40)
            begin
                queue_random_set();
                while (pending_requests.size() > 20)
                    @(posedge clk);
            end
            wait_quiet();
        end

        if (error_count == 0)
            $display("catmull_rom_table_fill test passed");
        else
            $display("catmull_rom_table_fill test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #100ms;
        $display("catmull_rom_table_fill test failed");
        $finish;
    end
endmodule

// File: catmull_rom_table_fill.f
+incdir+src
src/crt_fill_pkg.sv
src/catmull_rom_table_fill.sv
tb/testbench.sv
